>>> sv/tpwe_pkg.sv
package tpwe_pkg;

	localparam int CFG_DATA_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int LEN_W      = 5;
	localparam int IDX_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

	typedef enum logic [2:0] {
		OP_PILOT   = 3'd0,
		OP_SYNC    = 3'd1,
		OP_HEADER  = 3'd2,
		OP_DATA    = 3'd3,
		OP_TRAILER = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [2:0]        speed;
		logic              rate_is_48k;
		logic signed [2:0] symbol_offset;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             last;
	} pulse_t;

	localparam logic [LEN_W-1:0] LEN_PILOT     = 5'd12;
	localparam logic [LEN_W-1:0] LEN_SYNC_HEAD = 5'd28;
	localparam logic [LEN_W-1:0] LEN_ONE       = 5'd4;
	localparam logic [LEN_W-1:0] LEN_ZERO      = 5'd8;
	localparam logic [LEN_W-1:0] LEN_TWO       = 5'd2;
	localparam logic [LEN_W-1:0] LEN_THREE     = 5'd3;
	localparam logic [LEN_W-1:0] LEN_UNIT      = 5'd1;

	localparam logic [IDX_W-1:0] SYNC_LAST    = 6'd8;
	localparam logic [IDX_W-1:0] SYNC_GAP     = 6'd7;
	localparam logic [IDX_W-1:0] HEADER_BITS  = 6'd48;
	localparam logic [IDX_W-1:0] HEADER_LAST  = 6'd49;
	localparam logic [IDX_W-1:0] DATA_LAST    = 6'd7;
	localparam logic [IDX_W-1:0] TRAILER_LAST = 6'd3;

	localparam logic [2:0] FIRST_LEN [8][4] = '{
		'{3'd1, 3'd2, 3'd2, 3'd3}, '{3'd2, 3'd2, 3'd3, 3'd3},
		'{3'd2, 3'd3, 3'd3, 3'd4}, '{3'd3, 3'd3, 3'd4, 3'd4},
		'{3'd1, 3'd2, 3'd3, 3'd4}, '{3'd2, 3'd3, 3'd4, 3'd5},
		'{3'd2, 3'd3, 3'd4, 3'd5}, '{3'd3, 3'd4, 3'd5, 3'd6}};

	localparam logic [2:0] SECOND_LEN [8][4] = '{
		'{3'd1, 3'd1, 3'd2, 3'd2}, '{3'd1, 3'd2, 3'd2, 3'd3},
		'{3'd2, 3'd2, 3'd3, 3'd3}, '{3'd2, 3'd3, 3'd3, 3'd4},
		'{3'd1, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd2, 3'd3, 3'd4},
		'{3'd2, 3'd3, 3'd4, 3'd5}, '{3'd2, 3'd3, 3'd4, 3'd5}};

	localparam logic [7:0] REF_BASE [2][8] = '{
		'{8'hed, 8'hde, 8'hd2, 8'hc3, 8'h00, 8'h71, 8'h62, 8'h53},
		'{8'hf1, 8'he5, 8'hd6, 8'hc7, 8'h04, 8'h78, 8'h69, 8'h5d}};

	localparam logic [LEN_W-1:0] TAIL_LEN [2][8] = '{
		'{5'd21, 5'd22, 5'd23, 5'd24, 5'd23, 5'd24, 5'd25, 5'd26},
		'{5'd13, 5'd14, 5'd15, 5'd16, 5'd15, 5'd16, 5'd17, 5'd18}};

	function automatic logic op_known(input logic [2:0] op);
		return (op == OP_PILOT) || (op == OP_SYNC) || (op == OP_HEADER) ||
			(op == OP_DATA) || (op == OP_TRAILER);
	endfunction

	function automatic logic [7:0] ref_byte(input cfg_t cfg);
		logic [7:0] base;
		logic [6:0] off7;
		logic [6:0] adj;
		base = REF_BASE[cfg.rate_is_48k][cfg.speed];
		off7 = {{4{cfg.symbol_offset[2]}}, cfg.symbol_offset};
		adj  = base[6:0] + {off7[5:0], 1'b0} + off7;
		return {base[7], adj};
	endfunction

endpackage

>>> sv/tpwe_cfg_regs.sv
module tpwe_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [tpwe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpwe_pkg::CFG_DATA_W-1:0] cfg_data,
	output tpwe_pkg::cfg_t                  cfg
);
	import tpwe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_SPEED: begin
					cfg_q.speed <= cfg_data;
				end
				REG_RATE: begin
					cfg_q.rate_is_48k <= cfg_data[0];
				end
				REG_OFFSET: begin
					cfg_q.symbol_offset <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tpwe_pulse_calc.sv
module tpwe_pulse_calc (
	input  logic [2:0]                  opcode,
	input  logic [7:0]                  data_byte,
	input  logic [7:0]                  block_checksum,
	input  logic [tpwe_pkg::IDX_W-1:0]  idx,
	input  tpwe_pkg::cfg_t              cfg,
	output tpwe_pkg::pulse_t            pulse
);
	import tpwe_pkg::*;

	logic [23:0]      word;
	logic [4:0]       bit_sel;
	logic [1:0]       group;
	logic [LEN_W-1:0] tail;

	assign word    = {block_checksum, data_byte, ref_byte(cfg)};
	assign bit_sel = 5'd23 - idx[5:1];
	assign tail    = TAIL_LEN[cfg.rate_is_48k][cfg.speed];

	always_comb begin
		case (idx[2:1])
			2'd0: begin
				group = data_byte[7:6];
			end
			2'd1: begin
				group = data_byte[5:4];
			end
			2'd2: begin
				group = data_byte[3:2];
			end
			default: begin
				group = data_byte[1:0];
			end
		endcase
	end

	always_comb begin
		pulse.len  = LEN_PILOT;
		pulse.last = 1'b1;
		case (opcode)
			OP_PILOT: begin
				pulse.len  = LEN_PILOT;
				pulse.last = 1'b1;
			end
			OP_SYNC: begin
				pulse.last = (idx == SYNC_LAST);
				if (idx == '0) begin
					pulse.len = LEN_SYNC_HEAD;
				end else if (idx == SYNC_GAP) begin
					pulse.len = LEN_TWO;
				end else if (idx == SYNC_LAST) begin
					pulse.len = cfg.rate_is_48k ? LEN_ONE : LEN_ZERO;
				end else begin
					pulse.len = LEN_PILOT;
				end
			end
			OP_HEADER: begin
				pulse.last = (idx == HEADER_LAST);
				if (idx < HEADER_BITS) begin
					pulse.len = word[bit_sel] ? LEN_ONE : LEN_ZERO;
				end else if (!idx[0]) begin
					pulse.len = LEN_TWO;
				end else begin
					pulse.len = LEN_THREE;
				end
			end
			OP_DATA: begin
				pulse.last = (idx == DATA_LAST);
				if (!idx[0]) begin
					pulse.len = {2'b00, FIRST_LEN[cfg.speed][group]};
				end else begin
					pulse.len = {2'b00, SECOND_LEN[cfg.speed][group]};
				end
			end
			OP_TRAILER: begin
				pulse.last = (idx == TRAILER_LAST);
				case (idx[1:0])
					2'd0: begin
						pulse.len = tail >> 1;
					end
					2'd1: begin
						pulse.len = tail - (tail >> 1);
					end
					default: begin
						pulse.len = LEN_UNIT;
					end
				endcase
			end
			default: begin
				pulse.len  = LEN_PILOT;
				pulse.last = 1'b1;
			end
		endcase
	end

endmodule

>>> sv/tape_pulse_width_encoder.sv
// Encodes tape loader items into half-pulses, one result beat per clock unless the sink stalls. An
// accepted item is held in an input register while a pulse counter steps through its half-pulses;
// each pulse length is looked up combinationally and lands in the output register. A pilot gives
// one half-pulse, sync 9, header 50, a data byte 8 and a trailer 4; an unused opcode is dropped
// with no result. The next item is accepted in the cycle its predecessor's last pulse enters the
// output register, so a steady stream of data bytes is paced by its one pulse per cycle. The level
// toggles after every pulse and starts low after reset. The user must ensure configuration is
// written through the cfg port while no item is in flight; the block itself does not enforce it.
module tape_pulse_width_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [tpwe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpwe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      opcode,
	input  logic [7:0]                      data_byte,
	input  logic [7:0]                      block_checksum,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            level,
	output logic [tpwe_pkg::LEN_W-1:0]      pulse_length,
	output logic                            last_pulse
);
	import tpwe_pkg::*;

	cfg_t   cfg;
	pulse_t pulse;

	logic             item_valid_s1;
	logic [2:0]       opcode_s1;
	logic [7:0]       data_byte_s1;
	logic [7:0]       checksum_s1;
	logic [IDX_W-1:0] idx_q;

	logic             out_valid_q;
	logic             level_out_q;
	logic [LEN_W-1:0] length_q;
	logic             last_q;
	logic             cur_level_q;

	logic out_free;
	logic emit;
	logic done;
	logic in_take;

	tpwe_cfg_regs u_cfg_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	tpwe_pulse_calc u_pulse_calc (
		.opcode         (opcode_s1),
		.data_byte      (data_byte_s1),
		.block_checksum (checksum_s1),
		.idx            (idx_q),
		.cfg            (cfg),
		.pulse          (pulse)
	);

	assign out_free = !out_valid_q || out_ready;
	assign emit     = item_valid_s1 && op_known(opcode_s1) && out_free;
	assign done     = item_valid_s1 && (!op_known(opcode_s1) || (emit && pulse.last));
	assign in_ready = !item_valid_s1 || done;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			idx_q         <= '0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
			idx_q         <= '0;
		end else if (done) begin
			item_valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1    <= opcode;
			data_byte_s1 <= data_byte;
			checksum_s1  <= block_checksum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_level_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			cur_level_q <= ~cur_level_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			level_out_q <= cur_level_q;
			length_q    <= pulse.len;
			last_q      <= pulse.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign level        = level_out_q;
	assign pulse_length = length_q;
	assign last_pulse   = last_q;

endmodule

>>> sv/tpwe_checker.sv
module tpwe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [2:0]                 opcode,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       level,
	input logic [tpwe_pkg::LEN_W-1:0] pulse_length,
	input logic                       last_pulse
);
	import tpwe_pkg::*;

	logic seen_q;
	logic prev_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			prev_level_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			seen_q       <= 1'b1;
			prev_level_q <= level;
		end
	end

	// A result beat that waits for the sink keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pulse_length) &&
			$stable(level) && $stable(last_pulse))
		else $error("stalled result beat changed");

	// Successive half-pulses alternate in level.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && seen_q |-> level != prev_level_q)
		else $error("level did not toggle between pulses");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_length != '0 && pulse_length <= LEN_SYNC_HEAD)
		else $error("pulse length out of range");

	// Items with several pulses keep the input blocked for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_SYNC || opcode == OP_HEADER ||
			opcode == OP_DATA || opcode == OP_TRAILER) |=> !in_ready)
		else $error("input accepted while a multi-pulse item was in progress");

endmodule

bind tape_pulse_width_encoder tpwe_checker u_tpwe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level        (level),
	.pulse_length (pulse_length),
	.last_pulse   (last_pulse)
);
